// File: rtl/matrix3x3_inverse_unit_macros.svh
// assertion macros used by the checker file
`ifndef MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3X3_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define M3INV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define M3INV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/m3inv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package m3inv_pkg;

   localparam int ElemWidth  = 32;
   localparam int NumElems   = 9;
   localparam int ProdWidth  = 2 * ElemWidth;
   localparam int CofWidth   = ProdWidth + 1;
   localparam int CMagWidth  = CofWidth - 1;
   localparam int PartWidth  = ElemWidth + 33;
   localparam int DetWidth   = 98;
   localparam int MagWidth   = DetWidth - 1;
   localparam int QuoWidth   = 32;

   typedef logic signed [ElemWidth-1:0] elem_type;
   typedef logic [3:0] idx_type;

   typedef struct packed {
      elem_type a11;
      elem_type a12;
      elem_type a13;
      elem_type a21;
      elem_type a22;
      elem_type a23;
      elem_type a31;
      elem_type a32;
      elem_type a33;
   } req_type;

   typedef struct packed {
      elem_type b11;
      elem_type b12;
      elem_type b13;
      elem_type b21;
      elem_type b22;
      elem_type b23;
      elem_type b31;
      elem_type b32;
      elem_type b33;
      logic     singular;
      logic     clipped;
   } rsp_type;

   localparam elem_type SatPos = 32'sh7fffffff;
   localparam elem_type SatNeg = 32'sh80000000;
   localparam logic [QuoWidth-1:0] SatNegMag = 32'h80000000;

   // adjugate entry e = a[x]*a[y] - a[z]*a[w], row-major element order
   localparam idx_type CofTab [NumElems][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd7, 4'd2, 4'd8, 4'd1},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd8, 4'd0, 4'd6, 4'd2},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd6, 4'd1, 4'd7, 4'd0},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage
`default_nettype wire

// File: rtl/m3inv_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface m3inv_req_if;
   import m3inv_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface m3inv_rsp_if;
   import m3inv_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/matrix3x3_inverse_unit.sv
// throughput: one matrix per cycle; the 32 quotient bits come from 32 chained
// compare-subtract stages, nine lanes wide, one bit per stage
// a stalled response freezes every stage, so nothing is dropped or repeated
// reset clears the stage valid bits only; the datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   m3inv_req_if.sink   req_port,
   m3inv_rsp_if.source rsp_port
);
   import m3inv_pkg::*;

   localparam int Shift     = 2 * FRAC_BITS + 1;
   localparam int NumRaw    = (CMagWidth + Shift > MagWidth) ? CMagWidth + Shift : MagWidth;
   localparam int NumWidth  = NumRaw + 1;
   localparam int DshWidth  = MagWidth + 1;
   localparam int TopWidth  = DshWidth + QuoWidth;
   localparam int RemW      = (NumWidth > TopWidth) ? NumWidth : TopWidth;
   localparam int NumStages = 10 + QuoWidth;

   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic                 adv;

   elem_type                    a0_ff   [NumElems];
   logic signed [ProdWidth-1:0] p1_ff   [NumElems][2];
   elem_type                    r1_ff   [3];
   logic signed [CofWidth-1:0]  cof2_ff [NumElems];
   elem_type                    r2_ff   [3];
   logic signed [PartWidth-1:0] plo3_ff [3];
   logic signed [PartWidth-1:0] phi3_ff [3];
   logic signed [CofWidth-1:0]  cof3_ff [NumElems];
   logic signed [DetWidth-1:0]  term4_ff [3];
   logic signed [CofWidth-1:0]  cof4_ff [NumElems];
   logic signed [DetWidth-1:0]  det5_ff;
   logic signed [CofWidth-1:0]  cof5_ff [NumElems];
   logic [MagWidth-1:0]         dmag6_ff;
   logic [CMagWidth-1:0]        cmag6_ff [NumElems];
   logic [NumElems-1:0]         neg6_ff;
   logic [NumElems-1:0]         czero6_ff;
   logic                        sing6_ff;
   logic [RemW-1:0]             num7_ff [NumElems];
   logic [DshWidth-1:0]         dsh7_ff;
   logic [NumElems-1:0]         neg7_ff;
   logic [NumElems-1:0]         czero7_ff;
   logic                        sing7_ff;

   logic [RemW-1:0]     rem_ff   [QuoWidth+1][NumElems];
   logic [QuoWidth-1:0] quo_ff   [QuoWidth+1][NumElems];
   logic [DshWidth-1:0] dsh_ff   [QuoWidth+1];
   logic [NumElems-1:0] neg_ff   [QuoWidth+1];
   logic [NumElems-1:0] czero_ff [QuoWidth+1];
   logic [NumElems-1:0] ovf_ff   [QuoWidth+1];
   logic                sing_ff  [QuoWidth+1];

   elem_type            bout_ff [NumElems];
   elem_type            bout_in [NumElems];
   logic                sing_out_ff;
   logic                clip_out_ff;
   logic                clip_out_in;
   logic [NumElems-1:0] clip_in;

   assign adv            = !vld_ff[NumStages-1] || rsp_port.ready;
   assign req_port.ready = adv;
   assign vld_in         = {vld_ff[NumStages-2:0], req_port.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // front end: products, cofactors, determinant
   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff[0] <= req_port.data.a11;
         a0_ff[1] <= req_port.data.a12;
         a0_ff[2] <= req_port.data.a13;
         a0_ff[3] <= req_port.data.a21;
         a0_ff[4] <= req_port.data.a22;
         a0_ff[5] <= req_port.data.a23;
         a0_ff[6] <= req_port.data.a31;
         a0_ff[7] <= req_port.data.a32;
         a0_ff[8] <= req_port.data.a33;
         for (int e = 0; e < NumElems; e++) begin
            p1_ff[e][0] <= a0_ff[CofTab[e][0]] * a0_ff[CofTab[e][1]];
            p1_ff[e][1] <= a0_ff[CofTab[e][2]] * a0_ff[CofTab[e][3]];
            cof2_ff[e]  <= CofWidth'(p1_ff[e][0]) - CofWidth'(p1_ff[e][1]);
            cof3_ff[e]  <= cof2_ff[e];
            cof4_ff[e]  <= cof3_ff[e];
            cof5_ff[e]  <= cof4_ff[e];
         end
         for (int i = 0; i < 3; i++) begin
            r1_ff[i] <= a0_ff[i];
            r2_ff[i] <= r1_ff[i];
            // first-row element times its cofactor, split into 32x33 halves
            plo3_ff[i] <= r2_ff[i] * $signed({1'b0, cof2_ff[3*i][31:0]});
            phi3_ff[i] <= r2_ff[i] * $signed(cof2_ff[3*i][CofWidth-1:32]);
            term4_ff[i] <= DetWidth'(plo3_ff[i]) + (DetWidth'(phi3_ff[i]) <<< 32);
         end
         det5_ff <= term4_ff[0] + term4_ff[1] + term4_ff[2];
      end
   end

   // magnitudes, signs, the scaled numerator, then the first divider stage
   always_ff @(posedge clock) begin
      if (adv) begin
         dmag6_ff <= MagWidth'(det5_ff[DetWidth-1] ? -det5_ff : det5_ff);
         sing6_ff <= (det5_ff == '0);
         for (int e = 0; e < NumElems; e++) begin
            cmag6_ff[e]  <= CMagWidth'(cof5_ff[e][CofWidth-1] ? -cof5_ff[e] : cof5_ff[e]);
            neg6_ff[e]   <= cof5_ff[e][CofWidth-1] ^ det5_ff[DetWidth-1];
            czero6_ff[e] <= (cof5_ff[e] == '0);
         end
         // round to nearest: (2|c| * 2^2f + |d|) / 2|d|
         for (int e = 0; e < NumElems; e++) begin
            num7_ff[e] <= (RemW'(cmag6_ff[e]) << Shift) + RemW'(dmag6_ff);
         end
         dsh7_ff   <= {dmag6_ff, 1'b0};
         neg7_ff   <= neg6_ff;
         czero7_ff <= czero6_ff;
         sing7_ff  <= sing6_ff;
         for (int e = 0; e < NumElems; e++) begin
            ovf_ff[0][e] <= num7_ff[e] >= (RemW'(dsh7_ff) << QuoWidth);
            rem_ff[0][e] <= num7_ff[e];
            quo_ff[0][e] <= '0;
         end
         dsh_ff[0]   <= dsh7_ff;
         neg_ff[0]   <= neg7_ff;
         czero_ff[0] <= czero7_ff;
         sing_ff[0]  <= sing7_ff;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QuoWidth; k++) begin : g_div
      localparam int Bit = QuoWidth - 1 - k;
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int e = 0; e < NumElems; e++) begin
               if (rem_ff[k][e] >= (RemW'(dsh_ff[k]) << Bit)) begin
                  rem_ff[k+1][e] <= rem_ff[k][e] - (RemW'(dsh_ff[k]) << Bit);
                  quo_ff[k+1][e] <= quo_ff[k][e] | (QuoWidth'(1) << Bit);
               end else begin
                  rem_ff[k+1][e] <= rem_ff[k][e];
                  quo_ff[k+1][e] <= quo_ff[k][e];
               end
            end
            dsh_ff[k+1]   <= dsh_ff[k];
            neg_ff[k+1]   <= neg_ff[k];
            czero_ff[k+1] <= czero_ff[k];
            ovf_ff[k+1]   <= ovf_ff[k];
            sing_ff[k+1]  <= sing_ff[k];
         end
      end
   end

   // sign, saturation and the singular override
   always_comb begin
      logic [QuoWidth-1:0] q;
      logic                n;
      for (int e = 0; e < NumElems; e++) begin
         q = quo_ff[QuoWidth][e];
         n = neg_ff[QuoWidth][e];
         clip_in[e] = !czero_ff[QuoWidth][e] && (ovf_ff[QuoWidth][e] ||
                      (!n && q[QuoWidth-1]) || (n && (q > SatNegMag)));
         if (czero_ff[QuoWidth][e] || sing_ff[QuoWidth]) begin
            bout_in[e] = '0;
         end else if (clip_in[e]) begin
            bout_in[e] = n ? SatNeg : SatPos;
         end else if (n) begin
            bout_in[e] = elem_type'(QuoWidth'(0) - q);
         end else begin
            bout_in[e] = elem_type'(q);
         end
      end
      clip_out_in = (|clip_in) && !sing_ff[QuoWidth];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bout_ff     <= bout_in;
         sing_out_ff <= sing_ff[QuoWidth];
         clip_out_ff <= clip_out_in;
      end
   end

   assign rsp_port.valid         = vld_ff[NumStages-1];
   assign rsp_port.data.b11      = bout_ff[0];
   assign rsp_port.data.b12      = bout_ff[1];
   assign rsp_port.data.b13      = bout_ff[2];
   assign rsp_port.data.b21      = bout_ff[3];
   assign rsp_port.data.b22      = bout_ff[4];
   assign rsp_port.data.b23      = bout_ff[5];
   assign rsp_port.data.b31      = bout_ff[6];
   assign rsp_port.data.b32      = bout_ff[7];
   assign rsp_port.data.b33      = bout_ff[8];
   assign rsp_port.data.singular = sing_out_ff;
   assign rsp_port.data.clipped  = clip_out_ff;

endmodule
`default_nettype wire

// File: rtl/m3inv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "matrix3x3_inverse_unit_macros.svh"
module m3inv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input m3inv_pkg::rsp_type rsp_data
);
   import m3inv_pkg::*;

   `M3INV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response word changed while stalled")
   `M3INV_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid, "response valid straight after reset")
   `M3INV_ASSERT_SAME(a_ready_free, !rsp_valid, req_ready, "request blocked with output empty")
   `M3INV_ASSERT_SAME(a_singular_zero, rsp_valid && rsp_data.singular, !rsp_data.clipped && rsp_data.b11 == '0 && rsp_data.b12 == '0 && rsp_data.b13 == '0 && rsp_data.b21 == '0 && rsp_data.b22 == '0 && rsp_data.b23 == '0 && rsp_data.b31 == '0 && rsp_data.b32 == '0 && rsp_data.b33 == '0, "singular word not cleared")
   `M3INV_ASSERT_SAME(a_clip_sat, rsp_valid && rsp_data.clipped, rsp_data.b11 == SatPos || rsp_data.b11 == SatNeg || rsp_data.b12 == SatPos || rsp_data.b12 == SatNeg || rsp_data.b13 == SatPos || rsp_data.b13 == SatNeg || rsp_data.b21 == SatPos || rsp_data.b21 == SatNeg || rsp_data.b22 == SatPos || rsp_data.b22 == SatNeg || rsp_data.b23 == SatPos || rsp_data.b23 == SatNeg || rsp_data.b31 == SatPos || rsp_data.b31 == SatNeg || rsp_data.b32 == SatPos || rsp_data.b32 == SatNeg || rsp_data.b33 == SatPos || rsp_data.b33 == SatNeg, "clipped flag without a saturated element")

endmodule

bind matrix3x3_inverse_unit m3inv_checker u_m3inv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_data  (rsp_port.data)
);
`default_nettype wire
